>>> rtl/core/csmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmt_pkg
// shared constants and types of the cube shadow map test core
// ----------------------------------------------------------------------------
package csmt_pkg;
    localparam int MAP_SIZE   = 128;
    localparam int FACE_WORDS = MAP_SIZE * MAP_SIZE;
    localparam int STORE_DEPTH = 6 * FACE_WORDS;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int COORD_W    = $clog2(MAP_SIZE);
    localparam int DIV_STEPS  = COORD_W + 1;

    typedef enum logic [2:0] {
        CFG_LIGHT_X    = 3'd0,
        CFG_LIGHT_Y    = 3'd1,
        CFG_LIGHT_Z    = 3'd2,
        CFG_MAP_SIZE   = 3'd3,
        CFG_DEPTH_BIAS = 3'd4
    } cfg_index_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
endpackage

>>> rtl/core/csmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csmt_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module csmt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/core/cube_shadow_map_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_shadow_map_test_core
// point-light shadow test against six cube-face depth maps
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream. tuser carries req_type; a write item
// stores texel_depth at face/row/column when face is at most 5 and gives
// no result, a query item gives one result on the m_ stream (shadowed,
// face_used, light_distance). Configuration registers are written over the
// cfg_ channel while idle. Throughput is one item per cycle while the
// output is not stalled. A query result runs through difference, squares,
// face pick, size scaling, a texel-coordinate divider of one quotient bit
// per stage, the registered depth ram read, a sqrt of one root bit per
// stage and a final compare; the sqrt is a restoring one over the 52-bit sum.
// The whole pipeline advances when its output stage is empty, holds a write
// or is taken, so a stalled receiver holds every stage and s_tready falls;
// a write item already past the ram stage is never repeated. Reset clears
// valid bits and loads the register defaults; the depth store is undefined
// until written. Writes reach the ram at its write port in acceptance order;
// a query reads the ram at the same stage, so every earlier write has already
// landed and every later one lands afterwards, and no forwarding is needed.
// ----------------------------------------------------------------------------
module cube_shadow_map_test_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: face[2:0], texel_row[9:3], texel_col[16:10], texel_depth[40:17],
    //          point_x[64:41], point_y[88:65], point_z[112:89], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [119:0] s_tdata,
    // s_tuser: req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: shadowed[0], face_used[3:1], light_distance[27:4], zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import csmt_pkg::*;

    localparam int SQ_W   = 52;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int NUM_W  = 26 + COORD_W + 1;
    localparam int DEN_W  = 26;
    localparam int RAMST  = 4 + DIV_STEPS;
    localparam int NST    = RAMST + SQRT_STEPS;

    // configuration registers
    logic signed [23:0] light_x_reg, light_y_reg, light_z_reg;
    logic [7:0]  map_size_reg;
    logic [23:0] depth_bias_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg    <= 24'sd65536;
            light_y_reg    <= 24'sd32000;
            light_z_reg    <= 24'sd65536;
            map_size_reg   <= 8'd128;
            depth_bias_reg <= 24'd1792;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LIGHT_X:    light_x_reg    <= cfg_data;
                CFG_LIGHT_Y:    light_y_reg    <= cfg_data;
                CFG_LIGHT_Z:    light_z_reg    <= cfg_data;
                CFG_MAP_SIZE:   map_size_reg   <= cfg_data[7:0];
                CFG_DEPTH_BIAS: depth_bias_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // size in use
    logic [COORD_W:0] size_use;
    always_comb begin
        if (map_size_reg == 8'd0) begin
            size_use = (COORD_W+1)'(1);
        end else if ({1'b0, map_size_reg} > 9'(MAP_SIZE)) begin
            size_use = (COORD_W+1)'(MAP_SIZE);
        end else begin
            size_use = (COORD_W+1)'(map_size_reg);
        end
    end

    // pipeline payload per stage
    typedef struct packed {
        logic              query;
        logic [2:0]        wface;
        logic [COORD_W-1:0] wrow;
        logic [COORD_W-1:0] wcol;
        logic [23:0]       wdepth;
        logic signed [24:0] d0, d1, d2;
        logic [SQ_W-1:0]   sq;
        logic              zero;
        logic [2:0]        face;
        logic [NUM_W-1:0]  n0, n1;
        logic [DEN_W-1:0]  den;
        logic [COORD_W:0]  q0, q1;
        logic [23:0]       stored;
        logic [SQ_W-1:0]   rem;
        logic [SQ_W-1:0]   root;
        logic [SQ_W-1:0]   bitv;
        logic [24:0]       lhs;
    } stage_t;

    stage_t st_reg [NST+1];
    stage_t st_next [NST+1];

    // pipeline advance
    logic adv;
    logic [NST:0] vld_reg;
    assign adv = !(vld_reg[NST] && st_reg[NST].query) || m_tready;
    assign s_tready = adv;

    logic [24:0] m0, m1, m2;
    logic [23:0] ram_rd;
    logic        ram_we;
    logic [ADDR_W-1:0] ram_wa, ram_ra;

    always_comb begin
        stage_t p;
        logic [24:0] mm;
        logic [NUM_W-1:0] dd;
        logic [SQ_W-1:0] t;
        logic [COORD_W:0] c0, c1;
        // stage 0: input capture and difference
        p = '0;
        p.query  = s_tuser;
        p.wface  = s_tdata[2:0];
        p.wrow   = s_tdata[9:3];
        p.wcol   = s_tdata[16:10];
        p.wdepth = s_tdata[40:17];
        p.d0 = 25'($signed(s_tdata[64:41])) - 25'(light_x_reg);
        p.d1 = 25'($signed(s_tdata[88:65])) - 25'(light_y_reg);
        p.d2 = 25'($signed(s_tdata[112:89])) - 25'(light_z_reg);
        st_next[0] = p;
        // stage 1: magnitudes squared and summed
        p = st_reg[0];
        m0 = p.d0[24] ? 25'(-p.d0) : 25'(p.d0);
        m1 = p.d1[24] ? 25'(-p.d1) : 25'(p.d1);
        m2 = p.d2[24] ? 25'(-p.d2) : 25'(p.d2);
        p.sq = SQ_W'(m0 * m0) + SQ_W'(m1 * m1) + SQ_W'(m2 * m2);
        st_next[1] = p;
        // stage 2: major axis and face
        p = st_reg[1];
        mm = p.d0[24] ? 25'(-p.d0) : 25'(p.d0);
        begin
            logic [24:0] a1, a2;
            a1 = p.d1[24] ? 25'(-p.d1) : 25'(p.d1);
            a2 = p.d2[24] ? 25'(-p.d2) : 25'(p.d2);
            if (a1 > mm && a1 >= a2) begin
                mm = a1;
                p.face = p.d1 > 0 ? 3'd2 : 3'd3;
                p.n0 = NUM_W'(p.d0 + $signed(mm));
                p.n1 = NUM_W'(p.d2 + $signed(mm));
            end else if (a2 > mm && a2 > a1) begin
                mm = a2;
                p.face = p.d2 > 0 ? 3'd4 : 3'd5;
                p.n0 = NUM_W'(p.d0 + $signed(mm));
                p.n1 = NUM_W'(p.d1 + $signed(mm));
            end else begin
                p.face = p.d0 > 0 ? 3'd0 : 3'd1;
                p.n0 = NUM_W'(p.d1 + $signed(mm));
                p.n1 = NUM_W'(p.d2 + $signed(mm));
            end
        end
        p.zero = (mm == 25'd0);
        p.den  = DEN_W'({mm, 1'b0});
        st_next[2] = p;
        // stage 3: scale numerators by the size
        p = st_reg[2];
        p.n0 = NUM_W'(p.n0 * size_use);
        p.n1 = NUM_W'(p.n1 * size_use);
        p.q0 = '0;
        p.q1 = '0;
        st_next[3] = p;
        // stages 4..: restoring division, one quotient bit per stage
        for (int k = 0; k < DIV_STEPS; k++) begin
            p = st_reg[3+k];
            dd = NUM_W'(p.den) << (DIV_STEPS-1-k);
            if (!p.zero && p.n0 >= dd) begin
                p.n0 = p.n0 - dd;
                p.q0[DIV_STEPS-1-k] = 1'b1;
            end
            if (!p.zero && p.n1 >= dd) begin
                p.n1 = p.n1 - dd;
                p.q1[DIV_STEPS-1-k] = 1'b1;
            end
            st_next[4+k] = p;
        end
        // ram stage: clamp, address, read and texel write
        p = st_reg[RAMST-1];
        c0 = (p.q0 >= size_use) ? size_use - 1'b1 : p.q0;
        c1 = (p.q1 >= size_use) ? size_use - 1'b1 : p.q1;
        ram_ra = ADDR_W'(p.face) * ADDR_W'(FACE_WORDS)
               + ADDR_W'(c0[COORD_W-1:0]) * ADDR_W'(MAP_SIZE)
               + ADDR_W'(c1[COORD_W-1:0]);
        ram_we = vld_reg[RAMST-1] && adv && !p.query && p.wface <= 3'd5;
        ram_wa = ADDR_W'(p.wface) * ADDR_W'(FACE_WORDS)
               + ADDR_W'(p.wrow) * ADDR_W'(MAP_SIZE) + ADDR_W'(p.wcol);
        st_next[RAMST] = p;
        // first sqrt stage takes ram data
        p = st_reg[RAMST];
        p.stored = ram_rd;
        p.lhs  = 25'(ram_rd) + 25'(depth_bias_reg);
        p.rem  = p.sq;
        p.root = '0;
        p.bitv = SQ_W'(1) << (SQ_W-2);
        st_next[RAMST+1] = p;
        // sqrt stages, one root bit per stage
        for (int k = 0; k < SQRT_STEPS-1; k++) begin
            p = st_reg[RAMST+1+k];
            t = p.root + p.bitv;
            if (p.rem >= t) begin
                p.rem  = p.rem - t;
                p.root = (p.root >> 1) + p.bitv;
            end else begin
                p.root = p.root >> 1;
            end
            p.bitv = p.bitv >> 2;
            st_next[RAMST+2+k] = p;
        end
    end

    // ram bypass not needed: write and read of the same stage are ordered
    // because a write only lands at the ram stage after all earlier items
    csmt_ram #(.WIDTH(24), .DEPTH(STORE_DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (st_reg[RAMST-1].wdepth),
        .rd_en   (adv),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k <= NST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // output: last sqrt step done in final stage logic
    stage_t po;
    logic [SQ_W-1:0] root_f, t_f, rem_f;
    logic [23:0] dist_sat;
    logic        shad;
    always_comb begin
        po = st_reg[NST];
        t_f = po.root + po.bitv;
        rem_f = po.rem;
        root_f = (rem_f >= t_f) ? (po.root >> 1) + po.bitv : po.root >> 1;
        dist_sat = (root_f > SQ_W'(24'hFFFFFF)) ? 24'hFFFFFF : root_f[23:0];
        shad = !po.zero && po.stored != 24'd0
             && SQ_W'(po.lhs * po.lhs) < po.sq && ({1'b0, po.lhs} < 26'd33554432);
    end

    assign m_tvalid = vld_reg[NST] && st_reg[NST].query;
    assign m_tdata  = {4'd0, dist_sat, po.zero ? 3'd0 : po.face, shad};

    // assertions
    a_no_out_for_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st_reg[NST].query)
        else $error("result for a write item");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NST] |-> s_tready)
        else $error("input blocked with empty output stage");
endmodule

>>> sim/cube_shadow_map_test_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_shadow_map_test_core_test
// self-checking bench for the cube shadow map test core
// ----------------------------------------------------------------------------
// Texel writes and shadow queries are queued by a stimulus process and fed to
// the core by a bursty driver. An in-bench predictor keeps its own copy of
// the depth faces and the light registers and computes, for each query, the
// face, the saturated distance and the shadow flag; a monitor under a varying
// stall pattern compares every result transfer with the oldest prediction.
// Queries never read a texel that was not written: the stimulus writes the
// target texel first when needed. Several register settings are walked,
// extremes included, each applied only while the core is idle.
// ----------------------------------------------------------------------------
module cube_shadow_map_test_core_test;
    import csmt_pkg::*;

    typedef struct {
        logic        req;
        logic [2:0]  face;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [23:0] depth;
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] pz;
    } shadow_req_t;

    typedef struct {
        logic        shadowed;
        logic [2:0]  face;
        logic [23:0] distance;
    } shadow_res_t;

    typedef struct {
        bit          hit;
        logic [2:0]  face;
        int          addr;
        longint unsigned sq;
    } probe_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [23:0]  cfg_data;

    // predictor state
    logic signed [23:0] lit_x, lit_y, lit_z;
    logic [7:0]         face_size;
    logic [23:0]        bias;
    logic [23:0]        depth_mem [STORE_DEPTH];
    bit                 texel_set [STORE_DEPTH];

    shadow_req_t pending_reqs [$];
    shadow_res_t expected_res [$];
    int          errors;

    cube_shadow_map_test_core dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // face pick and texel address for a query point
    function automatic probe_t probe(logic signed [23:0] px, logic signed [23:0] py,
                                     logic signed [23:0] pz);
        longint d [3];
        longint mag [3];
        longint m;
        int     a, sz, k;
        int     c [2];
        probe_t p;
        d[0] = longint'(px) - longint'(lit_x);
        d[1] = longint'(py) - longint'(lit_y);
        d[2] = longint'(pz) - longint'(lit_z);
        p.sq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            p.sq += longint'(mag[i] * mag[i]);
        end
        a = 0;
        m = mag[0];
        for (int i = 1; i < 3; i++)
            if (mag[i] > m) begin
                m = mag[i];
                a = i;
            end
        p.hit  = (m != 0);
        p.face = 3'd0;
        p.addr = 0;
        if (!p.hit) return p;
        p.face = 3'(2 * a + (d[a] > 0 ? 0 : 1));
        sz = face_size == 0 ? 1 : (face_size > MAP_SIZE ? MAP_SIZE : int'(face_size));
        k = 0;
        for (int i = 0; i < 3; i++)
            if (i != a) begin
                c[k] = int'(((d[i] + m) * sz) / (2 * m));
                if (c[k] >= sz) c[k] = sz - 1;
                k++;
            end
        p.addr = int'(p.face) * FACE_WORDS + c[0] * MAP_SIZE + c[1];
        return p;
    endfunction

    function automatic shadow_req_t rand_req();
        shadow_req_t r;
        r.req   = 1'($urandom_range(0, 1));
        r.face  = 3'($urandom_range(0, 7));
        r.row   = 7'($urandom_range(0, 127));
        r.col   = 7'($urandom_range(0, 127));
        r.depth = 24'($urandom);
        r.px    = 24'($urandom);
        r.py    = 24'($urandom);
        r.pz    = 24'($urandom);
        return r;
    endfunction

    task automatic add_write(logic [2:0] f, logic [6:0] r, logic [6:0] c, logic [23:0] dep);
        shadow_req_t q;
        int          a;
        q       = rand_req();
        q.req   = REQ_WRITE;
        q.face  = f;
        q.row   = r;
        q.col   = c;
        q.depth = dep;
        if (f <= 3'd5) begin
            a = int'(f) * FACE_WORDS + int'(r) * MAP_SIZE + int'(c);
            depth_mem[a] = dep;
            texel_set[a] = 1'b1;
        end
        pending_reqs.push_back(q);
    endtask

    // query, with its target texel written first when still unset
    task automatic add_query(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
        shadow_req_t     q;
        shadow_res_t     e;
        probe_t          p;
        longint unsigned dist_val, lhs;
        longint          t;
        logic [23:0]     dep;
        p        = probe(px, py, pz);
        dist_val = int_sqrt(p.sq);
        if (p.hit && !texel_set[p.addr]) begin
            case ($urandom_range(0, 3))
                0: dep = 24'd0;
                1: begin
                    t = longint'(dist_val) - longint'(bias) + $urandom_range(0, 4) - 2;
                    dep = t < 1 ? 24'd1 : (t > 24'hFFFFFF ? 24'hFFFFFF : 24'(t));
                end
                2: dep = 24'($urandom);
                default: dep = 24'(dist_val >> 1);
            endcase
            add_write(3'(p.addr / FACE_WORDS), 7'((p.addr / MAP_SIZE) % MAP_SIZE),
                      7'(p.addr % MAP_SIZE), dep);
        end
        q     = rand_req();
        q.req = REQ_QUERY;
        q.px  = px;
        q.py  = py;
        q.pz  = pz;
        pending_reqs.push_back(q);
        e.face     = p.face;
        e.distance = dist_val > 64'hFFFFFF ? 24'hFFFFFF : 24'(dist_val);
        e.shadowed = 1'b0;
        if (p.hit && depth_mem[p.addr] != 0) begin
            lhs = longint'(depth_mem[p.addr]) + longint'(bias);
            e.shadowed = (lhs * lhs < p.sq);
        end
        expected_res.push_back(e);
    endtask

    task automatic add_offset_query(int ox, int oy, int oz);
        add_query(24'(lit_x + ox), 24'(lit_y + oy), 24'(lit_z + oz));
    endtask

    function automatic logic [23:0] near_coord(logic signed [23:0] base);
        int sh;
        int delta;
        sh    = $urandom_range(0, 23);
        delta = int'($urandom & ((32'd1 << sh) - 1));
        if ($urandom_range(0, 1)) delta = -delta;
        return 24'(base + delta);
    endfunction

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_res.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LIGHT_X:    lit_x = val;
            CFG_LIGHT_Y:    lit_y = val;
            CFG_LIGHT_Z:    lit_z = val;
            CFG_MAP_SIZE:   face_size = val[7:0];
            CFG_DEPTH_BIAS: bias = val;
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: add_write(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                                   7'($urandom_range(0, 127)), 24'($urandom));
                3:       add_query(lit_x, lit_y, lit_z);
                4, 5:    add_query(24'($urandom), 24'($urandom), 24'($urandom));
                default: add_query(near_coord(lit_x), near_coord(lit_y), near_coord(lit_z));
            endcase
        end
        wait_idle();
    endtask

    // stimulus and phases
    initial begin
        cfg_valid = 1'b0;
        cfg_index = CFG_LIGHT_X;
        cfg_data  = '0;
        errors    = 0;
        lit_x     = 24'sd65536;
        lit_y     = 24'sd32000;
        lit_z     = 24'sd65536;
        face_size = 8'd128;
        bias      = 24'd1792;
        aresetn   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each face, axis ties, zero direction, bad writes, extremes
        add_offset_query(0, 0, 0);
        add_offset_query(1000, 10, -20);
        add_offset_query(-1000, 10, -20);
        add_offset_query(30, 2000, 5);
        add_offset_query(30, -2000, 5);
        add_offset_query(-7, 40, 3000);
        add_offset_query(-7, 40, -3000);
        add_offset_query(256, 256, 0);
        add_offset_query(-256, 0, -256);
        add_offset_query(0, 512, 512);
        add_offset_query(300, -300, 300);
        add_write(3'd6, 7'd0, 7'd0, 24'hFFFFFF);
        add_write(3'd7, 7'd127, 7'd127, 24'hABCDEF);
        add_write(3'd0, 7'd127, 7'd127, 24'hFFFFFF);
        add_write(3'd5, 7'd0, 7'd0, 24'd1);
        add_query(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_query(24'h800000, 24'h800000, 24'h800000);
        add_query(24'h7FFFFF, 24'h800000, 24'h000000);
        add_query(24'h000000, 24'h000000, 24'h800000);
        add_offset_query(1000, 10, -20);
        wait_idle();

        random_phase(200);

        write_reg(CFG_LIGHT_X, 24'h800000);
        write_reg(CFG_LIGHT_Y, 24'h800000);
        write_reg(CFG_LIGHT_Z, 24'h800000);
        write_reg(CFG_MAP_SIZE, 24'd1);
        write_reg(CFG_DEPTH_BIAS, 24'd0);
        add_query(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        random_phase(190);

        write_reg(CFG_LIGHT_X, 24'h7FFFFF);
        write_reg(CFG_LIGHT_Y, 24'h7FFFFF);
        write_reg(CFG_LIGHT_Z, 24'h7FFFFF);
        write_reg(CFG_MAP_SIZE, 24'd0);
        write_reg(CFG_DEPTH_BIAS, 24'hFFFFFF);
        add_query(24'h800000, 24'h800000, 24'h800000);
        random_phase(190);

        write_reg(CFG_LIGHT_X, 24'h000000);
        write_reg(CFG_LIGHT_Y, 24'hFFF000);
        write_reg(CFG_LIGHT_Z, 24'h001234);
        write_reg(CFG_MAP_SIZE, 24'd255);
        write_reg(CFG_DEPTH_BIAS, 24'd256);
        random_phase(200);

        write_reg(CFG_MAP_SIZE, 24'd7);
        write_reg(CFG_DEPTH_BIAS, 24'd0);
        random_phase(200);

        write_reg(CFG_LIGHT_X, 24'($urandom));
        write_reg(CFG_LIGHT_Y, 24'($urandom));
        write_reg(CFG_LIGHT_Z, 24'($urandom));
        write_reg(CFG_MAP_SIZE, 24'd128);
        write_reg(CFG_DEPTH_BIAS, 24'd1792);
        random_phase(200);

        if (expected_res.size() != 0) begin
            $error("results missing: %0d", expected_res.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // driver: bursts of transfers with random gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        shadow_req_t r;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.req;
                s_tdata  <= {7'd0, r.pz, r.py, r.px, r.depth, r.col, r.row, r.face};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result check
    int stall_mode;
    int mode_left;
    always @(posedge aclk) begin
        shadow_res_t e;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= $urandom_range(0, 3) == 0;
            endcase
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result transfer %h", m_tdata);
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    if (m_tdata[0] !== e.shadowed) begin
                        $error("shadowed: expected %0d, actual %0d", e.shadowed, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[3:1] !== e.face) begin
                        $error("face_used: expected %0d, actual %0d", e.face, m_tdata[3:1]);
                        errors++;
                    end
                    if (m_tdata[27:4] !== e.distance) begin
                        $error("light_distance: expected %h, actual %h", e.distance,
                               m_tdata[27:4]);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

>>> sim.f
rtl/core/csmt_pkg.sv
rtl/core/csmt_ram.sv
rtl/core/cube_shadow_map_test_core.sv
sim/cube_shadow_map_test_core_test.sv
